// File: rtl/two_point_touch_calibration_unit_defines.svh
// ----------------------------------------------------------------------------
// Touch calibration assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_TOUCH_CALIBRATION_UNIT_DEFINES_SVH
`define TWO_POINT_TOUCH_CALIBRATION_UNIT_DEFINES_SVH

// same-cycle implication
`define TPC_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// Touch calibration package
// Widths, reset values, codes and shared types of the calibration unit.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int FIXED_SCALE_DEF = 1000;

	localparam int DIM_W     = 12;
	localparam int MARGIN_W  = 10;
	localparam int LSPAN_W   = 14;
	localparam int COEF_W    = 32;
	localparam int MAP_W     = 12;
	localparam int PTS_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int M_DATA_W  = ((2 * MAP_W + 7) / 8) * 8;
	localparam int M_USER_W  = 2 + PTS_W;

	localparam logic [MAP_W-1:0] MAP_MAX = 12'd4095;

	localparam logic [DIM_W-1:0]    SCREEN_WIDTH_RST  = 12'd800;
	localparam logic [DIM_W-1:0]    SCREEN_HEIGHT_RST = 12'd480;
	localparam logic [MARGIN_W-1:0] TARGET_MARGIN_RST = 10'd30;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MARGIN = 2'd2;

	localparam logic FUNC_SAMPLE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WAIT,
		ST_PUSH
	} tpc_state_t;

	typedef enum logic [2:0] {
		AX_IDLE,
		AX_MUL1,
		AX_LOAD,
		AX_DIV,
		AX_FIX,
		AX_MUL2,
		AX_DONE
	} axis_state_t;

	typedef struct packed {
		logic start;
		logic map_mode;
	} axis_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} axis_sts_t;

endpackage

// File: rtl/two_point_touch_calibration_unit.sv
// ----------------------------------------------------------------------------
// Two-point touch calibration unit
// After reset or a restart word the first touch sample is taken as the raw
// reading of the target (margin, margin) and the second as that of
// (width - margin, height - margin); from them each axis gets a 32-bit slope
// and offset, and every later sample is mapped to a pixel clamped to 0..4095.
// Every input word gives one result word. A restart, a first point or a
// zero-span fault is answered without the axes; a mapped sample goes through
// one multiply and one divide, and the second calibration point through a
// multiply, a divide and a second multiply. Each axis has a bit-serial
// multiplier (one multiplier bit a cycle) and a restoring divider (one
// quotient bit a cycle); both axes run side by side. One word is in work at
// a time, and the next is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "two_point_touch_calibration_unit_defines.svh"

module two_point_touch_calibration_unit #(
	parameter int COORD_BITS  = tpc_pkg::COORD_BITS_DEF,
	parameter int FIXED_SCALE = tpc_pkg::FIXED_SCALE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// raw_x, raw_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// func
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// mapped_x, mapped_y
	output logic [tpc_pkg::M_DATA_W-1:0]    m_tdata,
	// calibrated, points_taken, span_fault
	output logic [tpc_pkg::M_USER_W-1:0]    m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpc_pkg::DIM_W-1:0]       cfg_data
);

	localparam int MAP_W  = tpc_pkg::MAP_W;
	localparam int PTS_W  = tpc_pkg::PTS_W;
	localparam int LSPAN_W = tpc_pkg::LSPAN_W;

	tpc_pkg::tpc_state_t state_q, state_d;

	logic [tpc_pkg::DIM_W-1:0]    screen_width_q, screen_height_q;
	logic [tpc_pkg::MARGIN_W-1:0] target_margin_q;

	logic                  func_q;
	logic [COORD_BITS-1:0] raw_x_q, raw_y_q;
	logic [COORD_BITS-1:0] first_point_x_q, first_point_y_q;
	logic [PTS_W-1:0]      point_count_q;
	logic                  map_mode_q;

	logic [MAP_W-1:0] res_x_q, res_y_q;
	logic             res_cal_q, res_fault_q;
	logic [PTS_W-1:0] res_pts_q;

	logic             m_tvalid_q;
	logic [MAP_W-1:0] out_x_q, out_y_q;
	logic             out_cal_q, out_fault_q;
	logic [PTS_W-1:0] out_pts_q;

	tpc_pkg::axis_ctl_t ax_ctl;
	tpc_pkg::axis_sts_t sts_x, sts_y;
	logic [MAP_W-1:0]   mapped_x_w, mapped_y_w;

	logic signed [LSPAN_W-1:0] lspan_x, lspan_y;
	logic             span_zero;
	logic             pc_we, fp_we, res_we, out_load;
	logic [PTS_W-1:0] pc_d, res_pts_d;
	logic [MAP_W-1:0] res_x_d, res_y_d;
	logic             res_cal_d, res_fault_d;

	assign lspan_x = $signed(LSPAN_W'(screen_width_q))
		- $signed(LSPAN_W'({target_margin_q, 1'b0}));
	assign lspan_y = $signed(LSPAN_W'(screen_height_q))
		- $signed(LSPAN_W'({target_margin_q, 1'b0}));
	assign span_zero = (raw_x_q == first_point_x_q) || (raw_y_q == first_point_y_q);

	tpc_axis #(
		.COORD_BITS (COORD_BITS),
		.FIXED_SCALE(FIXED_SCALE)
	) u_axis_x (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ax_ctl),
		.margin(target_margin_q),
		.lspan (lspan_x),
		.p0    (first_point_x_q),
		.raw   (raw_x_q),
		.sts   (sts_x),
		.mapped(mapped_x_w)
	);

	tpc_axis #(
		.COORD_BITS (COORD_BITS),
		.FIXED_SCALE(FIXED_SCALE)
	) u_axis_y (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ax_ctl),
		.margin(target_margin_q),
		.lspan (lspan_y),
		.p0    (first_point_y_q),
		.raw   (raw_y_q),
		.sts   (sts_y),
		.mapped(mapped_y_w)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= tpc_pkg::SCREEN_WIDTH_RST;
			screen_height_q <= tpc_pkg::SCREEN_HEIGHT_RST;
			target_margin_q <= tpc_pkg::TARGET_MARGIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpc_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				tpc_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				tpc_pkg::CFG_TARGET_MARGIN: target_margin_q <= cfg_data[tpc_pkg::MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ax_ctl      = '0;
		pc_we       = 1'b0;
		pc_d        = point_count_q;
		fp_we       = 1'b0;
		res_we      = 1'b0;
		res_x_d     = '0;
		res_y_d     = '0;
		res_cal_d   = 1'b0;
		res_pts_d   = '0;
		res_fault_d = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			tpc_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = tpc_pkg::ST_DECODE;
			end
			tpc_pkg::ST_DECODE: begin
				if (func_q == tpc_pkg::FUNC_RESTART) begin
					pc_we   = 1'b1;
					pc_d    = 2'd0;
					res_we  = 1'b1;
					state_d = tpc_pkg::ST_PUSH;
				end else begin
					case (point_count_q)
						2'd0: begin
							fp_we     = 1'b1;
							pc_we     = 1'b1;
							pc_d      = 2'd1;
							res_we    = 1'b1;
							res_pts_d = 2'd1;
							state_d   = tpc_pkg::ST_PUSH;
						end
						2'd1: begin
							if (span_zero) begin
								// drop the first point and report the fault
								pc_we       = 1'b1;
								pc_d        = 2'd0;
								res_we      = 1'b1;
								res_fault_d = 1'b1;
								state_d     = tpc_pkg::ST_PUSH;
							end else begin
								ax_ctl.start    = 1'b1;
								ax_ctl.map_mode = 1'b0;
								state_d         = tpc_pkg::ST_WAIT;
							end
						end
						default: begin
							ax_ctl.start    = 1'b1;
							ax_ctl.map_mode = 1'b1;
							state_d         = tpc_pkg::ST_WAIT;
						end
					endcase
				end
			end
			tpc_pkg::ST_WAIT: begin
				if (sts_x.done && sts_y.done) begin
					res_we    = 1'b1;
					res_cal_d = 1'b1;
					res_pts_d = 2'd2;
					if (map_mode_q) begin
						res_x_d = mapped_x_w;
						res_y_d = mapped_y_w;
					end else begin
						pc_we = 1'b1;
						pc_d  = 2'd2;
					end
					state_d = tpc_pkg::ST_PUSH;
				end
			end
			tpc_pkg::ST_PUSH: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = tpc_pkg::ST_IDLE;
				end
			end
			default: state_d = tpc_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == tpc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q   <= '0;
			first_point_x_q <= '0;
			first_point_y_q <= '0;
			map_mode_q      <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (pc_we) point_count_q <= pc_d;
			if (fp_we) begin
				first_point_x_q <= raw_x_q;
				first_point_y_q <= raw_y_q;
			end
			if (ax_ctl.start) map_mode_q <= ax_ctl.map_mode;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q  <= s_tuser;
			raw_x_q <= s_tdata[COORD_BITS-1:0];
			raw_y_q <= s_tdata[2*COORD_BITS-1:COORD_BITS];
		end
		if (res_we) begin
			res_x_q     <= res_x_d;
			res_y_q     <= res_y_d;
			res_cal_q   <= res_cal_d;
			res_pts_q   <= res_pts_d;
			res_fault_q <= res_fault_d;
		end
		if (out_load) begin
			out_x_q     <= res_x_q;
			out_y_q     <= res_y_q;
			out_cal_q   <= res_cal_q;
			out_pts_q   <= res_pts_q;
			out_fault_q <= res_fault_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tpc_pkg::M_DATA_W'({out_y_q, out_x_q});
	assign m_tuser  = {out_fault_q, out_pts_q, out_cal_q};

	`TPC_ASSERT_HOLD(ax_lockstep_a, (sts_x.done || sts_y.done), (sts_x.done && sts_y.done), "axes out of step")
	`TPC_ASSERT_NEXT(ax_start_a, ax_ctl.start, (sts_x.busy && sts_y.busy), "axis ignored start")
	`TPC_ASSERT_HOLD(wait_busy_a, (state_q == tpc_pkg::ST_WAIT), sts_x.busy, "waiting on an idle axis")
	`TPC_ASSERT_HOLD(fault_word_a, (m_tvalid_q && out_fault_q), (!out_cal_q && out_pts_q == 2'd0), "fault word claims calibration")
	`TPC_ASSERT_HOLD(count_range_a, 1'b1, (point_count_q != 2'd3), "point count out of range")

endmodule

// File: rtl/tpc_axis.sv
// ----------------------------------------------------------------------------
// Touch calibration axis datapath
// Bit-serial multiplier and restoring divider for one axis; forms slope and
// offset from two points, or maps a raw reading through them.
// ----------------------------------------------------------------------------
`include "two_point_touch_calibration_unit_defines.svh"

module tpc_axis #(
	parameter int COORD_BITS  = tpc_pkg::COORD_BITS_DEF,
	parameter int FIXED_SCALE = tpc_pkg::FIXED_SCALE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tpc_pkg::axis_ctl_t                ctl,
	input  logic [tpc_pkg::MARGIN_W-1:0]      margin,
	input  logic signed [tpc_pkg::LSPAN_W-1:0] lspan,
	input  logic [COORD_BITS-1:0]             p0,
	input  logic [COORD_BITS-1:0]             raw,
	output tpc_pkg::axis_sts_t                sts,
	output logic [tpc_pkg::MAP_W-1:0]         mapped
);

	localparam int FS_W  = $clog2(FIXED_SCALE + 1);
	localparam int MB_W  = (COORD_BITS > FS_W) ? COORD_BITS : FS_W;
	localparam int ACC_W = tpc_pkg::COEF_W + COORD_BITS + 1;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam logic [MB_W-1:0]  FS_MB     = MB_W'(FIXED_SCALE);
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MB_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W - 1);
	localparam int COEF_W = tpc_pkg::COEF_W;
	localparam int MAP_W  = tpc_pkg::MAP_W;

	tpc_pkg::axis_state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              map_q;
	logic [ACC_W-1:0]  acc_q, a_q, dvd_q;
	logic [MB_W-1:0]   b_q, dv_q, rem_q;
	logic [COEF_W-1:0] acc2_q, a2_q;
	logic              neg_q, psneg_q;
	logic [COEF_W-1:0] slope_q, offset_q;
	logic [MAP_W-1:0]  mapped_q;

	logic [ACC_W-1:0]  acc_nx, acc_mag;
	logic [COEF_W-1:0] acc2_nx, q32, slope_nx;
	logic [MB_W:0]     r2, r_diff;
	logic              ge;
	logic [MB_W-1:0]   rem_nx;
	logic [COORD_BITS-1:0] pdiff;
	logic [MAP_W-1:0]  map_nx;

	// shift-add step: one multiplier bit per cycle, subtract while forming the offset
	always_comb begin
		acc_nx = acc_q;
		if (b_q[0]) begin
			if (state_q == tpc_pkg::AX_MUL2) begin
				acc_nx = acc_q - a_q;
			end else begin
				acc_nx = acc_q + a_q;
			end
		end
	end

	assign acc2_nx = b_q[0] ? (acc2_q + a2_q) : acc2_q;
	assign acc_mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	// restoring division, one quotient bit per cycle
	assign r2     = {rem_q, dvd_q[ACC_W-1]};
	assign r_diff = r2 - {1'b0, dv_q};
	assign ge     = (r2 >= {1'b0, dv_q});
	assign rem_nx = ge ? r_diff[MB_W-1:0] : r2[MB_W-1:0];

	assign q32      = dvd_q[COEF_W-1:0];
	assign slope_nx = (neg_q ^ psneg_q) ? (~q32 + 1'b1) : q32;
	assign pdiff    = (raw >= p0) ? (raw - p0) : (p0 - raw);

	always_comb begin
		if (neg_q) begin
			map_nx = '0;
		end else if (|dvd_q[ACC_W-1:MAP_W]) begin
			map_nx = tpc_pkg::MAP_MAX;
		end else begin
			map_nx = dvd_q[MAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpc_pkg::AX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpc_pkg::AX_IDLE: begin
				if (ctl.start) state_d = tpc_pkg::AX_MUL1;
			end
			tpc_pkg::AX_MUL1: begin
				if (cnt_q == '0) state_d = tpc_pkg::AX_LOAD;
			end
			tpc_pkg::AX_LOAD: state_d = tpc_pkg::AX_DIV;
			tpc_pkg::AX_DIV: begin
				if (cnt_q == '0) state_d = tpc_pkg::AX_FIX;
			end
			tpc_pkg::AX_FIX: begin
				state_d = map_q ? tpc_pkg::AX_DONE : tpc_pkg::AX_MUL2;
			end
			tpc_pkg::AX_MUL2: begin
				if (cnt_q == '0) state_d = tpc_pkg::AX_DONE;
			end
			tpc_pkg::AX_DONE: state_d = tpc_pkg::AX_IDLE;
			default: state_d = tpc_pkg::AX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			map_q    <= 1'b0;
			slope_q  <= '0;
			offset_q <= '0;
		end else begin
			unique case (state_q)
				tpc_pkg::AX_IDLE: begin
					if (ctl.start) begin
						map_q <= ctl.map_mode;
						cnt_q <= MUL_LAST;
					end
				end
				tpc_pkg::AX_MUL1, tpc_pkg::AX_DIV, tpc_pkg::AX_MUL2: begin
					cnt_q <= cnt_q - 1'b1;
				end
				tpc_pkg::AX_LOAD: cnt_q <= DIV_LAST;
				tpc_pkg::AX_FIX: begin
					cnt_q <= MUL_LAST;
					if (!map_q) slope_q <= slope_nx;
				end
				tpc_pkg::AX_DONE: begin
					if (!map_q) offset_q <= acc_q[COEF_W-1:0];
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tpc_pkg::AX_IDLE: begin
				if (ctl.start) begin
					acc2_q <= '0;
					a2_q   <= COEF_W'(margin);
					if (ctl.map_mode) begin
						a_q   <= ACC_W'($signed(slope_q));
						b_q   <= MB_W'(raw);
						acc_q <= ACC_W'($signed(offset_q));
						dv_q  <= FS_MB;
					end else begin
						a_q     <= ACC_W'(lspan);
						b_q     <= FS_MB;
						acc_q   <= '0;
						dv_q    <= MB_W'(pdiff);
						psneg_q <= (raw < p0);
					end
				end
			end
			tpc_pkg::AX_MUL1: begin
				acc_q  <= acc_nx;
				acc2_q <= acc2_nx;
				a_q    <= {a_q[ACC_W-2:0], 1'b0};
				a2_q   <= {a2_q[COEF_W-2:0], 1'b0};
				b_q    <= {1'b0, b_q[MB_W-1:1]};
			end
			tpc_pkg::AX_LOAD: begin
				dvd_q <= acc_mag;
				neg_q <= acc_q[ACC_W-1];
				rem_q <= '0;
			end
			tpc_pkg::AX_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[ACC_W-2:0], ge};
			end
			tpc_pkg::AX_FIX: begin
				if (map_q) begin
					mapped_q <= map_nx;
				end else begin
					// offset starts from scale * margin, then takes off slope * p0
					a_q   <= ACC_W'($signed(slope_nx));
					b_q   <= MB_W'(p0);
					acc_q <= ACC_W'($signed(acc2_q));
				end
			end
			tpc_pkg::AX_MUL2: begin
				acc_q <= acc_nx;
				a_q   <= {a_q[ACC_W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[MB_W-1:1]};
			end
			default: begin
			end
		endcase
	end

	assign sts.busy = (state_q != tpc_pkg::AX_IDLE);
	assign sts.done = (state_q == tpc_pkg::AX_DONE);
	assign mapped   = mapped_q;

	`TPC_ASSERT_HOLD(ax_div_nonzero_a, (state_q == tpc_pkg::AX_DIV), (dv_q != '0), "axis divides by zero")

endmodule

// File: tb/sv/two_point_touch_calibration_unit_tb.sv
// ----------------------------------------------------------------------------
// Two-point touch calibration unit testbench
// Drives touch and restart words into the stream input. Computes the expected
// mapped pixel, calibration flags and span fault for each accepted word, and
// checks every output word against the oldest pending expectation. The run
// covers directed corner cases, configuration extremes, a long output stall,
// and random calibration sessions under several idling patterns.
// ----------------------------------------------------------------------------
module two_point_touch_calibration_unit_tb;
	import tpc_pkg::*;

	localparam int     COORD_W     = COORD_BITS_DEF;
	localparam longint FIX_SCALE   = FIXED_SCALE_DEF;
	localparam int     S_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
	localparam int     HOLD_CYCLES = 300;
	localparam int     DRAIN_TAIL  = 100;

	typedef struct packed {
		logic [MAP_W-1:0] mapped_x;
		logic [MAP_W-1:0] mapped_y;
		logic             calibrated;
		logic [PTS_W-1:0] points_taken;
		logic             span_fault;
	} touch_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [M_USER_W-1:0]   m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIM_W-1:0]      cfg_data;

	// calibration state as the block should hold it
	logic [DIM_W-1:0]    screen_w_q;
	logic [DIM_W-1:0]    screen_h_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [COORD_W-1:0]  first_x_q;
	logic [COORD_W-1:0]  first_y_q;
	logic [1:0]          points_q;
	int                  slope_x_q;
	int                  offset_x_q;
	int                  slope_y_q;
	int                  offset_y_q;

	touch_result_t expected_results[$];
	int            mismatch_count;
	int            items_sent;
	int            src_idle_pct;
	int            sink_idle_pct;
	int            hold_seq;
	int            hold_seen;
	int            hold_left;

	two_point_touch_calibration_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1200000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic bit fit_axis(input longint log0, input longint log1,
			input longint phys0, input longint phys1, output int slope, output int offset);
		longint pspan;
		longint ratio;
		slope = 0;
		offset = 0;
		pspan = phys1 - phys0;
		if (pspan == 0)
			return 1'b0;
		ratio = (FIX_SCALE * (log1 - log0)) / pspan;
		slope = int'(ratio);
		// offset wraps to 32 bits
		offset = int'(FIX_SCALE * log0 - longint'(slope) * phys0);
		return 1'b1;
	endfunction

	function automatic logic [MAP_W-1:0] map_to_pixel(input int slope, input int offset,
			input logic [COORD_W-1:0] raw);
		longint pix;
		pix = (longint'(slope) * longint'(raw) + longint'(offset)) / FIX_SCALE;
		if (pix < 0)
			return '0;
		if (pix > longint'(MAP_MAX))
			return MAP_MAX;
		return pix[MAP_W-1:0];
	endfunction

	function automatic touch_result_t predict_touch(input logic func,
			input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry);
		touch_result_t res;
		int            sx, ox, sy, oy;
		bit            fit_x, fit_y;
		longint        m;
		res = '0;
		m = longint'(margin_q);
		if (func == FUNC_RESTART) begin
			points_q = 2'd0;
		end else if (points_q == 2'd0) begin
			first_x_q = rx;
			first_y_q = ry;
			points_q = 2'd1;
		end else if (points_q == 2'd1) begin
			fit_x = fit_axis(m, longint'(screen_w_q) - m, longint'(first_x_q), longint'(rx),
				sx, ox);
			fit_y = fit_axis(m, longint'(screen_h_q) - m, longint'(first_y_q), longint'(ry),
				sy, oy);
			if (fit_x && fit_y) begin
				slope_x_q = sx;
				offset_x_q = ox;
				slope_y_q = sy;
				offset_y_q = oy;
				points_q = 2'd2;
				res.calibrated = 1'b1;
			end else begin
				points_q = 2'd0;
				res.span_fault = 1'b1;
			end
		end else begin
			res.mapped_x = map_to_pixel(slope_x_q, offset_x_q, rx);
			res.mapped_y = map_to_pixel(slope_y_q, offset_y_q, ry);
			res.calibrated = 1'b1;
		end
		res.points_taken = points_q;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		touch_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: m_tdata=%h m_tuser=%h",
					m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("mapped_x", want.mapped_x, m_tdata[MAP_W-1:0]);
				compare_field("mapped_y", want.mapped_y, m_tdata[2*MAP_W-1:MAP_W]);
				compare_field("calibrated", want.calibrated, m_tuser[0]);
				compare_field("points_taken", want.points_taken, m_tuser[PTS_W:1]);
				compare_field("span_fault", want.span_fault, m_tuser[PTS_W+1]);
			end
		end
	end

	// output ready: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------
	task automatic send_touch(input logic func, input logic [COORD_W-1:0] rx,
			input logic [COORD_W-1:0] ry);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= S_DATA_W'({ry, rx});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(predict_touch(func, rx, ry));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_restart();
		send_touch(FUNC_RESTART, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// hold the input until every pending result has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SCREEN_WIDTH: screen_w_q = value;
			CFG_SCREEN_HEIGHT: screen_h_q = value;
			CFG_TARGET_MARGIN: margin_q = value[MARGIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
			input logic [MARGIN_W-1:0] margin);
		wait_results_drained();
		write_register(CFG_SCREEN_WIDTH, width);
		write_register(CFG_SCREEN_HEIGHT, height);
		write_register(CFG_TARGET_MARGIN, DIM_W'(margin));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// calibrate with two points, then map a few samples
	task automatic calibrate_and_map(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
			input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1, input int n_samples);
		send_restart();
		send_touch(FUNC_SAMPLE, x0, y0);
		send_touch(FUNC_SAMPLE, x1, y1);
		send_touch(FUNC_SAMPLE, '0, '1);
		send_touch(FUNC_SAMPLE, '1, '0);
		repeat (n_samples)
			send_touch(FUNC_SAMPLE, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// well-formed sessions with random content, mixed with noise and broken ones
	task automatic drive_random_sessions(input int n_items);
		int                 stop_at;
		logic [COORD_W-1:0] p1x, p1y, p2x, p2y;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 12) begin
				send_touch(1'($urandom), COORD_W'($urandom), COORD_W'($urandom));
			end else begin
				if (points_q != 2'd0 || $urandom_range(3) == 0)
					send_restart();
				if ($urandom_range(1) == 1) begin
					p1x = COORD_W'($urandom_range(1200, 50));
					p1y = COORD_W'($urandom_range(1200, 50));
				end else begin
					p1x = COORD_W'($urandom);
					p1y = COORD_W'($urandom);
				end
				send_touch(FUNC_SAMPLE, p1x, p1y);
				// leave roughly one session in ten after the first point
				if ($urandom_range(9) != 0) begin
					if ($urandom_range(1) == 1) begin
						p2x = COORD_W'($urandom_range(4050, 2900));
						p2y = COORD_W'($urandom_range(4050, 2900));
					end else begin
						p2x = COORD_W'($urandom);
						p2y = COORD_W'($urandom);
					end
					case ($urandom_range(24))
						0: p2x = p1x;
						1: p2y = p1y;
						2: begin
							p2x = p1x;
							p2y = p1y;
						end
						default: ;
					endcase
					send_touch(FUNC_SAMPLE, p2x, p2y);
					repeat ($urandom_range(12))
						send_touch(FUNC_SAMPLE, COORD_W'($urandom), COORD_W'($urandom));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		set_idling(0, 0);
		// restart before and after a first point, reset configuration
		send_touch(FUNC_SAMPLE, 12'd100, 12'd200);
		send_touch(FUNC_RESTART, '1, '1);
		send_touch(FUNC_RESTART, '0, '0);
		// full-range points, then the corners and the middle
		send_touch(FUNC_SAMPLE, '0, '0);
		send_touch(FUNC_SAMPLE, '1, '1);
		send_touch(FUNC_SAMPLE, '0, '0);
		send_touch(FUNC_SAMPLE, '1, '1);
		send_touch(FUNC_SAMPLE, 12'd2048, 12'd2048);
		// reversed panel: negative raw span
		send_touch(FUNC_RESTART, '0, '0);
		send_touch(FUNC_SAMPLE, '1, '1);
		send_touch(FUNC_SAMPLE, '0, '0);
		send_touch(FUNC_SAMPLE, '0, '1);
		send_touch(FUNC_SAMPLE, '1, '0);
		// zero span on X, on Y, on both
		send_touch(FUNC_RESTART, '0, '0);
		send_touch(FUNC_SAMPLE, 12'd500, 12'd600);
		send_touch(FUNC_SAMPLE, 12'd500, 12'd3000);
		send_touch(FUNC_SAMPLE, 12'd500, 12'd600);
		send_touch(FUNC_SAMPLE, 12'd3500, 12'd600);
		send_touch(FUNC_SAMPLE, 12'd1234, 12'd1234);
		send_touch(FUNC_SAMPLE, 12'd1234, 12'd1234);
		// steep slope drives samples past both clamps
		send_touch(FUNC_SAMPLE, 12'd2000, 12'd2000);
		send_touch(FUNC_SAMPLE, 12'd2100, 12'd2100);
		send_touch(FUNC_SAMPLE, '0, '0);
		send_touch(FUNC_SAMPLE, '1, '1);
		wait_results_drained();
	endtask

	task automatic test_config_extremes();
		set_idling(0, 0);
		set_config(12'd1, 12'd1, 10'd0);
		calibrate_and_map(12'd100, 12'd100, 12'd200, 12'd200, 2);
		set_config(12'd4095, 12'd4095, 10'd1023);
		calibrate_and_map(12'd300, 12'd300, 12'd3800, 12'd3800, 2);
		// margin above half the screen: negative logical span
		set_config(12'd800, 12'd480, 10'd1023);
		calibrate_and_map(12'd300, 12'd400, 12'd3800, 12'd3600, 2);
		// largest slope, offset wraps
		set_config(12'd4095, 12'd4095, 10'd0);
		calibrate_and_map(12'd4094, 12'd4094, 12'd4095, 12'd4095, 2);
		wait_results_drained();
	endtask

	task automatic test_output_backpressure();
		set_idling(0, 0);
		set_config(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, TARGET_MARGIN_RST);
		hold_seq++;
		calibrate_and_map(12'd300, 12'd300, 12'd3800, 12'd3800, 18);
		wait_results_drained();
	endtask

	task automatic test_random_slow_sink();
		set_idling(20, 81);
		set_config(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, TARGET_MARGIN_RST);
		drive_random_sessions(90);
		set_config(DIM_W'($urandom_range(4095, 1)), DIM_W'($urandom_range(4095, 1)),
			MARGIN_W'($urandom_range(120)));
		drive_random_sessions(90);
	endtask

	task automatic test_random_slow_source();
		set_idling(81, 20);
		set_config(12'd4095, 12'd4095, 10'd1023);
		drive_random_sessions(90);
		set_config(DIM_W'($urandom_range(4095, 1)), DIM_W'($urandom_range(4095, 1)),
			MARGIN_W'($urandom_range(1023)));
		drive_random_sessions(90);
	endtask

	task automatic test_random_full_rate();
		set_idling(0, 0);
		set_config(12'd1, 12'd1, 10'd0);
		drive_random_sessions(90);
		set_config(DIM_W'($urandom_range(4095, 1)), DIM_W'($urandom_range(4095, 1)),
			MARGIN_W'($urandom_range(200)));
		drive_random_sessions(90);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = FUNC_SAMPLE;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data = '0;
		screen_w_q = SCREEN_WIDTH_RST;
		screen_h_q = SCREEN_HEIGHT_RST;
		margin_q = TARGET_MARGIN_RST;
		first_x_q = '0;
		first_y_q = '0;
		points_q = 2'd0;
		slope_x_q = 0;
		offset_x_q = 0;
		slope_y_q = 0;
		offset_y_q = 0;
		mismatch_count = 0;
		items_sent = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_seq = 0;
		hold_seen = 0;
		hold_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_config_extremes();
		test_output_backpressure();
		test_random_slow_sink();
		test_random_slow_source();
		test_random_full_rate();

		wait_results_drained();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: two_point_touch_calibration_unit.f
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_axis.sv
rtl/two_point_touch_calibration_unit.sv
tb/sv/two_point_touch_calibration_unit_tb.sv
